// File: rtl/gsa_pkg.sv
package gsa_pkg;

    // Default table size and the cap on freed items reported by one frame op.
    localparam int SLOT_COUNT_DEF = 64;
    localparam int MAX_RESULTS    = 64;
    localparam logic [7:0] DELAY_RESET = 8'd2;

    // Operation codes.
    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_BIND    = 3'd1;
    localparam logic [2:0] OP_LOOKUP  = 3'd2;
    localparam logic [2:0] OP_DESTROY = 3'd3;
    localparam logic [2:0] OP_FRAME   = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_INDEX = 3'd1;
    localparam logic [2:0] ST_STALE     = 3'd2;
    localparam logic [2:0] ST_NO_RES    = 3'd3;
    localparam logic [2:0] ST_PENDING   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_APOP,
        S_AGEN,
        S_SCAN,
        S_FLUSH
    } t_state;

    // One entry of the deferred-free queue.
    typedef struct packed {
        logic [31:0] deadline;
        logic [7:0]  slot;
    } t_defer_entry;

    // Control broadcast to every cell of the queue.
    typedef struct packed {
        logic         shift;
        logic         ins;
        logic [7:0]   ins_pos;
        t_defer_entry ins_data;
    } t_cell_ctrl;

endpackage

// File: rtl/gsa_defer_cell.sv
module gsa_defer_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                  i_clk,
    input  gsa_pkg::t_cell_ctrl   i_ctrl,
    input  gsa_pkg::t_defer_entry i_next,
    output gsa_pkg::t_defer_entry o_entry
);
    import gsa_pkg::*;

    t_defer_entry r_entry;
    t_defer_entry n_entry;

    // An insert aimed at this position wins over the shift toward the head.
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins && (i_ctrl.ins_pos == 8'(CELL_IDX))) begin
            n_entry = i_ctrl.ins_data;
        end else if (i_ctrl.shift) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// File: rtl/generational_slot_allocator_core.sv
// Bind, lookup, destroy and an alloc that grows the table present a registered result from the
// execute state; an alloc that reuses a freed slot first reads the stack, then the generation.
// A frame op walks the defer queue through its cell chain, one entry per cycle unless a freed
// item waits on a busy output, and gives its final result from the flush state after the walk.
// The core takes one item at a time and accepts a new one only when idle. Reset (synchronous,
// active low) empties the table, stack and queue.
module generational_slot_allocator_core #(
    parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_slot_index,
    input  logic [15:0] i_generation,
    input  logic        i_created_ok,
    input  logic [31:0] i_frame_number,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_result_index,
    output logic [15:0] o_result_generation,
    output logic        o_slot_freed,
    output logic        o_last
);
    import gsa_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    // Control and item registers.
    t_state            r_state, n_state;
    logic [2:0]        r_op, n_op;
    logic [7:0]        r_idx, n_idx;
    logic [15:0]       r_gen, n_gen;
    logic              r_ok, n_ok;
    logic [31:0]       r_cur, n_cur;
    logic [7:0]        r_delay;
    logic [CW-1:0]     r_siu, n_siu;
    logic [CW-1:0]     r_fcnt, n_fcnt;
    logic [CW-1:0]     r_dcount, n_dcount;
    logic [CW-1:0]     r_scan, n_scan;
    logic [6:0]        r_nfree, n_nfree;
    logic              r_held_valid, n_held_valid;
    logic [IW-1:0]     r_held_slot, n_held_slot;
    logic [IW-1:0]     r_s, n_s;
    logic [SLOT_COUNT-1:0] r_has, n_has;
    logic [SLOT_COUNT-1:0] r_pend, n_pend;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_o_status, n_o_status;
    logic [5:0]        r_o_idx, n_o_idx;
    logic [15:0]       r_o_gen, n_o_gen;
    logic              r_o_freed, n_o_freed;
    logic              r_o_last, n_o_last;

    // Memories.
    logic [15:0]       gen_mem [SLOT_COUNT];
    logic [IW-1:0]     stk_mem [SLOT_COUNT];
    logic [15:0]       r_gen_rd;
    logic [IW-1:0]     r_stk_rd;
    logic              w_gen_we;
    logic [IW-1:0]     w_gen_waddr;
    logic [15:0]       w_gen_wdata;
    logic [IW-1:0]     w_gen_raddr;
    logic              w_stk_we;
    logic [IW-1:0]     w_stk_waddr;
    logic [IW-1:0]     w_stk_wdata;
    logic [IW-1:0]     w_stk_raddr;
    logic [CW-1:0]     w_fcnt_dec;

    // Queue cells.
    t_cell_ctrl        w_ctrl;
    t_defer_entry      w_entry [SLOT_COUNT];
    t_defer_entry      w_head;

    logic              w_accept;
    logic              w_out_free;
    logic              w_due;
    logic              w_head_inuse;
    logic [IW-1:0]     w_head_slot;
    logic              w_in_range;
    logic [IW-1:0]     w_ri;
    logic              w_gen_ok;
    logic [2:0]        w_create_st;
    logic [2:0]        w_full_st;
    logic [32:0]       w_sum;
    logic [31:0]       w_deadline;
    logic [2:0]        w_st;
    logic [15:0]       w_gen_inc;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_head     = w_entry[0];
    assign w_head_slot  = w_head.slot[IW-1:0];
    assign w_head_inuse = (9'(w_head.slot) < 9'(r_siu));
    assign w_due = (w_head.deadline <= r_cur) && (r_nfree < 7'(MAX_RESULTS));
    assign w_fcnt_dec = r_fcnt - CW'(1);
    assign w_gen_inc  = r_gen_rd + 16'd1;

    // Handle checks against the table.
    assign w_ri       = r_idx[IW-1:0];
    assign w_in_range = (9'(r_idx) < 9'(r_siu));
    assign w_gen_ok   = (r_gen_rd == r_gen);
    always_comb begin
        if (!w_in_range) begin
            w_create_st = ST_BAD_INDEX;
        end else if (!w_gen_ok) begin
            w_create_st = ST_STALE;
        end else if (r_pend[w_ri]) begin
            w_create_st = ST_PENDING;
        end else begin
            w_create_st = ST_OK;
        end
        if (!w_in_range) begin
            w_full_st = ST_BAD_INDEX;
        end else if (!w_gen_ok) begin
            w_full_st = ST_STALE;
        end else if (!r_has[w_ri]) begin
            w_full_st = ST_NO_RES;
        end else if (r_pend[w_ri]) begin
            w_full_st = ST_PENDING;
        end else begin
            w_full_st = ST_OK;
        end
    end

    // Saturating destroy deadline.
    assign w_sum      = {1'b0, r_cur} + {25'd0, r_delay};
    assign w_deadline = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];

    // Memory read addresses.
    assign w_stk_raddr = w_fcnt_dec[IW-1:0];
    always_comb begin
        case (r_state)
            S_IDLE:  w_gen_raddr = i_slot_index[IW-1:0];
            S_APOP:  w_gen_raddr = r_stk_rd;
            S_AGEN:  w_gen_raddr = r_s;
            default: w_gen_raddr = r_idx[IW-1:0];
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_opcode)
                        OP_ALLOC:   n_state = (r_fcnt != '0) ? S_APOP : S_EXEC;
                        OP_BIND:    n_state = S_EXEC;
                        OP_LOOKUP:  n_state = S_EXEC;
                        OP_DESTROY: n_state = S_EXEC;
                        OP_FRAME:   n_state = S_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_EXEC:  if (w_out_free) n_state = S_IDLE;
            S_APOP:  n_state = S_AGEN;
            S_AGEN:  if (w_out_free) n_state = S_IDLE;
            S_SCAN:  if (r_scan == '0) n_state = S_FLUSH;
            S_FLUSH: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_op = r_op;
        n_idx = r_idx;
        n_gen = r_gen;
        n_ok = r_ok;
        n_cur = r_cur;
        n_siu = r_siu;
        n_fcnt = r_fcnt;
        n_dcount = r_dcount;
        n_scan = r_scan;
        n_nfree = r_nfree;
        n_held_valid = r_held_valid;
        n_held_slot = r_held_slot;
        n_s = r_s;
        n_has = r_has;
        n_pend = r_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_status = r_o_status;
        n_o_idx = r_o_idx;
        n_o_gen = r_o_gen;
        n_o_freed = r_o_freed;
        n_o_last = r_o_last;
        w_gen_we = 1'b0;
        w_gen_waddr = r_s;
        w_gen_wdata = w_gen_inc;
        w_stk_we = 1'b0;
        w_stk_waddr = r_fcnt[IW-1:0];
        w_stk_wdata = w_head_slot;
        w_ctrl = '0;
        w_st = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op = i_opcode;
                    n_idx = i_slot_index;
                    n_gen = i_generation;
                    n_ok = i_created_ok;
                    if (i_opcode == OP_FRAME) begin
                        n_cur = i_frame_number;
                        n_scan = r_dcount;
                        n_nfree = '0;
                        n_held_valid = 1'b0;
                    end
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_idx = '0;
                    n_o_gen = '0;
                    n_o_freed = 1'b0;
                    n_o_last = 1'b1;
                    case (r_op)
                        OP_ALLOC: begin
                            // Stack is empty here: grow the table or report full.
                            if (r_siu < CW'(SLOT_COUNT)) begin
                                w_gen_we = 1'b1;
                                w_gen_waddr = r_siu[IW-1:0];
                                w_gen_wdata = 16'd1;
                                n_has[r_siu[IW-1:0]] = 1'b0;
                                n_pend[r_siu[IW-1:0]] = 1'b0;
                                n_siu = r_siu + CW'(1);
                                n_o_idx = 6'(8'(r_siu[IW-1:0]));
                                n_o_gen = 16'd1;
                                w_st = ST_OK;
                            end else begin
                                w_st = ST_FULL;
                            end
                        end
                        OP_BIND: begin
                            w_st = w_create_st;
                            if (w_create_st == ST_OK) begin
                                if (r_ok) begin
                                    n_has[w_ri] = 1'b1;
                                end else begin
                                    w_st = ST_NO_RES;
                                end
                            end
                        end
                        OP_LOOKUP: w_st = w_full_st;
                        OP_DESTROY: begin
                            w_st = w_full_st;
                            if (w_full_st == ST_OK) begin
                                if (r_dcount >= CW'(SLOT_COUNT)) begin
                                    w_st = ST_FULL;
                                end else begin
                                    n_pend[w_ri] = 1'b1;
                                    w_ctrl.ins = 1'b1;
                                    w_ctrl.ins_pos = 8'(r_dcount);
                                    w_ctrl.ins_data.deadline = w_deadline;
                                    w_ctrl.ins_data.slot = r_idx;
                                    n_dcount = r_dcount + CW'(1);
                                end
                            end
                        end
                        default: w_st = ST_OK;
                    endcase
                    n_o_status = w_st;
                end
            end
            S_APOP: begin
                n_s = r_stk_rd;
                n_fcnt = w_fcnt_dec;
            end
            S_AGEN: begin
                if (w_out_free) begin
                    w_gen_we = 1'b1;
                    n_pend[r_s] = 1'b0;
                    n_out_valid = 1'b1;
                    n_o_status = ST_OK;
                    n_o_idx = 6'(8'(r_s));
                    n_o_gen = w_gen_inc;
                    n_o_freed = 1'b0;
                    n_o_last = 1'b1;
                end
            end
            S_SCAN: begin
                // One queue entry leaves the head each step; kept ones rejoin at the tail.
                if ((r_scan != '0) && (!w_due || !r_held_valid || w_out_free)) begin
                    w_ctrl.shift = 1'b1;
                    n_scan = r_scan - CW'(1);
                    if (!w_due) begin
                        w_ctrl.ins = 1'b1;
                        w_ctrl.ins_pos = 8'(r_dcount - CW'(1));
                        w_ctrl.ins_data = w_head;
                    end else begin
                        n_dcount = r_dcount - CW'(1);
                        if (w_head_inuse) begin
                            n_has[w_head_slot] = 1'b0;
                            n_pend[w_head_slot] = 1'b0;
                            if (r_fcnt < CW'(SLOT_COUNT)) begin
                                w_stk_we = 1'b1;
                                n_fcnt = r_fcnt + CW'(1);
                            end
                        end
                        if (r_held_valid) begin
                            n_out_valid = 1'b1;
                            n_o_status = ST_OK;
                            n_o_idx = 6'(8'(r_held_slot));
                            n_o_gen = '0;
                            n_o_freed = 1'b1;
                            n_o_last = 1'b0;
                        end
                        n_held_valid = 1'b1;
                        n_held_slot = w_head_slot;
                        n_nfree = r_nfree + 7'd1;
                    end
                end
            end
            S_FLUSH: begin
                // Final result of a frame op carries the last flag.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status = ST_OK;
                    n_o_idx = r_held_valid ? 6'(8'(r_held_slot)) : 6'd0;
                    n_o_gen = '0;
                    n_o_freed = r_held_valid;
                    n_o_last = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_out_ready;
            end
        endcase
    end

    // Deferred-free queue as a chain of cells.
    genvar gi;
    generate
        for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
            t_defer_entry w_next;
            if (gi == SLOT_COUNT - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_entry[gi + 1];
            end
            gsa_defer_cell #(
                .CELL_IDX (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_next  (w_next),
                .o_entry (w_entry[gi])
            );
        end
    endgenerate

    // Generation memory.
    always_ff @(posedge i_clk) begin
        if (w_gen_we) begin
            gen_mem[w_gen_waddr] <= w_gen_wdata;
        end
        r_gen_rd <= gen_mem[w_gen_raddr];
    end

    // Free stack memory.
    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            stk_mem[w_stk_waddr] <= w_stk_wdata;
        end
        r_stk_rd <= stk_mem[w_stk_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_delay <= DELAY_RESET;
            r_cur <= '0;
            r_siu <= '0;
            r_fcnt <= '0;
            r_dcount <= '0;
            r_scan <= '0;
            r_nfree <= '0;
            r_held_valid <= 1'b0;
            r_has <= '0;
            r_pend <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_delay <= i_cfg_data;
            end
            r_cur <= n_cur;
            r_siu <= n_siu;
            r_fcnt <= n_fcnt;
            r_dcount <= n_dcount;
            r_scan <= n_scan;
            r_nfree <= n_nfree;
            r_held_valid <= n_held_valid;
            r_has <= n_has;
            r_pend <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_idx <= n_idx;
        r_gen <= n_gen;
        r_ok <= n_ok;
        r_s <= n_s;
        r_held_slot <= n_held_slot;
        r_o_status <= n_o_status;
        r_o_idx <= n_o_idx;
        r_o_gen <= n_o_gen;
        r_o_freed <= n_o_freed;
        r_o_last <= n_o_last;
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_status            = r_o_status;
    assign o_result_index      = r_o_idx;
    assign o_result_generation = r_o_gen;
    assign o_slot_freed        = r_o_freed;
    assign o_last              = r_o_last;

    // The queue never holds more entries than the table has slots.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcount <= CW'(SLOT_COUNT))
        else $error("defer queue count exceeds slot count");

    // One frame op reports no more freed slots than the result cap.
    a_freed_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfree <= 7'(MAX_RESULTS))
        else $error("frame op freed more slots than allowed");

    // A step that frees a slot while one is held must place the held item on the output.
    a_held_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && (r_scan != '0) && w_due && r_held_valid && w_out_free
        |=> o_out_valid && o_slot_freed && !o_last)
        else $error("held freed slot was not emitted");

endmodule
